[src/rpdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpdd_pkg;

  // Field widths
  localparam int COUNT_W    = 16;
  localparam int DEMAND_W   = 16;
  localparam int MS_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0] MIN_PULSE_RESET  = 16'd23975;
  localparam logic [COUNT_W-1:0] MAX_PULSE_RESET  = 16'd47939;
  localparam logic [MS_W-1:0]    TIMEOUT_MS_RESET = 8'd20;

  // Saturation limits
  localparam logic [DEMAND_W-1:0] DEMAND_FULL = 16'hFFFF;
  localparam logic [MS_W-1:0]     MS_MAX      = 8'd255;

  // Item kinds
  localparam logic KIND_PULSE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] rise_count;
    logic [COUNT_W-1:0] fall_count;
  } in_item_t;

  typedef struct packed {
    logic [DEMAND_W-1:0] demand;
    logic                stale;
  } out_item_t;

  // Divider handshake
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[src/rpdd_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend must be
// below the divisor, so the quotient is a pure fraction of DEMAND_W bits.
module rpdd_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rpdd_pkg::div_ctrl_t           ctrl,
  input  wire logic [rpdd_pkg::DEMAND_W-1:0] dividend,
  input  wire logic [rpdd_pkg::DEMAND_W-1:0] divisor,
  output rpdd_pkg::div_stat_t                stat,
  output logic [rpdd_pkg::DEMAND_W-1:0]      quotient
);

  localparam int QW    = rpdd_pkg::DEMAND_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

  logic [QW-1:0]    rem;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [QW:0] shifted;
  logic [QW:0] diff;
  logic        fits;

  // Shift in a zero and try the subtract
  always_comb begin
    shifted = {rem, 1'b0};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // Control: run QW steps after start, then flag done for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= dividend;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[QW-1:0] : shifted[QW-1:0];
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

`default_nettype wire

[src/rc_pulse_demand_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// RC pulse demand decoder.
// Input channel (item_valid / item_stall / item): a pulse item carries the
// rise and fall capture counts; a tick item marks one millisecond.
// Output channel (result_valid / result_stall / result): one result per
// item with the Q16 demand and the stale flag.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min_pulse,
// 1 max_pulse, 2 timeout_ms); write only while no item is in flight.
// Flow: a pulse that needs the divide passes the signal and check states,
// the 16 steps of the restoring divider, the divider done flag and the output
// register; a pulse that saturates or is zero skips the divider, and a tick
// goes straight to the done state. One item is in work at a time: item_stall
// holds while an item is in work, so a new item waits until the last is through.
// The output register lets a new item be accepted while a result waits.
// A stalled result holds; a finished item waits until the output is free.
// Reset returns the registers to their defaults, clears the demand and the
// millisecond counter, and empties the output.
module rc_pulse_demand_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire rpdd_pkg::in_item_t                item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output rpdd_pkg::out_item_t                    result,
  input  wire logic                              cfg_we,
  input  wire logic [rpdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SIGNAL = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  localparam int CW = rpdd_pkg::COUNT_W;
  localparam int DW = rpdd_pkg::DEMAND_W;
  localparam int MW = rpdd_pkg::MS_W;

  state_t state;
  state_t state_next;

  logic [CW-1:0] min_pulse;
  logic [CW-1:0] max_pulse;
  logic [MW-1:0] timeout_ms;

  logic [DW-1:0] demand_value;
  logic [MW-1:0] ms_since_pulse;

  logic          kind_r;
  logic [CW-1:0] width_r;
  logic [DW-1:0] signal_r;
  logic [DW-1:0] range_r;
  logic          range_ok_r;
  logic [DW-1:0] res_r;

  logic accept;
  logic out_free;
  logic stale_now;

  rpdd_pkg::div_ctrl_t     div_ctrl;
  rpdd_pkg::div_stat_t     div_stat;
  logic [DW-1:0]           div_quotient;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign stale_now  = ms_since_pulse > timeout_ms;

  // Start the divide only when the signal is nonzero, the range is valid and the quotient is a proper fraction
  always_comb begin
    div_ctrl.start = 1'b0;
    if (state == ST_CHECK && signal_r != '0 && range_ok_r && signal_r < range_r) begin
      div_ctrl.start = 1'b1;
    end
  end

  rpdd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (signal_r),
    .divisor  (range_r),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // Sequence one item
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.kind == rpdd_pkg::KIND_PULSE) ? ST_SIGNAL : ST_DONE;
        end
      end
      ST_SIGNAL: state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = div_ctrl.start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse  <= rpdd_pkg::MIN_PULSE_RESET;
      max_pulse  <= rpdd_pkg::MAX_PULSE_RESET;
      timeout_ms <= rpdd_pkg::TIMEOUT_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpdd_pkg::REG_MIN_PULSE:  min_pulse  <= cfg_data[CW-1:0];
        rpdd_pkg::REG_MAX_PULSE:  max_pulse  <= cfg_data[CW-1:0];
        rpdd_pkg::REG_TIMEOUT_MS: timeout_ms <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item, then derive signal and range, then resolve the result
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= item.kind;
      width_r <= item.fall_count - item.rise_count;
    end
    if (state == ST_SIGNAL) begin
      signal_r   <= (width_r > min_pulse) ? (width_r - min_pulse) : '0;
      range_r    <= max_pulse - min_pulse;
      range_ok_r <= max_pulse > min_pulse;
    end
    if (state == ST_CHECK) begin
      res_r <= (signal_r == '0) ? '0 : rpdd_pkg::DEMAND_FULL;
    end
    if (state == ST_DIV && div_stat.done) begin
      res_r <= div_quotient;
    end
  end

  // Advance the millisecond counter on an accepted tick, clear it on an accepted pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_since_pulse <= '0;
    end else if (accept) begin
      if (item.kind == rpdd_pkg::KIND_PULSE) begin
        ms_since_pulse <= '0;
      end else if (ms_since_pulse != rpdd_pkg::MS_MAX) begin
        ms_since_pulse <= ms_since_pulse + 1'b1;
      end
    end
  end

  // Update the demand and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      demand_value <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        priority if (stale_now) begin
          demand_value <= '0;
        end else if (kind_r == rpdd_pkg::KIND_PULSE) begin
          demand_value <= res_r;
        end
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      priority if (stale_now) begin
        result.demand <= '0;
      end else if (kind_r == rpdd_pkg::KIND_PULSE) begin
        result.demand <= res_r;
      end else begin
        result.demand <= demand_value;
      end
      result.stale <= stale_now;
    end
  end

  // Checks
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> state == ST_DIV)
    else $error("divider active outside the divide state");

  a_pulse_not_stale: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && kind_r == rpdd_pkg::KIND_PULSE) |-> ms_since_pulse == '0)
    else $error("pulse item finishing with a nonzero millisecond count");

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.stale) |-> result.demand == '0)
    else $error("stale result with nonzero demand");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result raised without a finished item");

endmodule

`default_nettype wire
